/* hw/rtl/thbt_pkg.sv */
// ----------------------------------------------------------------------------
// thbt_pkg
// Shared types and constants for the tap/hold button controller with a
// delayed tare: payload structs, configuration set and register indexes.
// ----------------------------------------------------------------------------
package thbt_pkg;

    // Widths of fixed fields.
    localparam int WEIGHT_W   = 16;
    localparam int DEBOUNCE_W = 12;
    localparam int HOLD_W     = 14;
    localparam int DELAY_W    = 14;
    localparam int LOCKOUT_W  = 12;
    localparam int TOL_W      = 10;
    localparam int MIN_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE = 12'd200;
    localparam logic [HOLD_W-1:0]     RST_HOLD     = 14'd1000;
    localparam logic [DELAY_W-1:0]    RST_DELAY    = 14'd1500;
    localparam logic                  RST_GUARD    = 1'b0;
    localparam logic [LOCKOUT_W-1:0]  RST_LOCKOUT  = 12'd500;
    localparam logic [TOL_W-1:0]      RST_TOL      = 10'd50;
    localparam logic [MIN_W-1:0]      RST_MIN      = 10'd50;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_HOLD     = 3'd1,
        CFG_DELAY    = 3'd2,
        CFG_GUARD    = 3'd3,
        CFG_LOCKOUT  = 3'd4,
        CFG_TOL      = 3'd5,
        CFG_MIN      = 3'd6
    } t_cfg_idx;

    // One tick of input.
    typedef struct packed {
        logic                       touch_level;
        logic                       sleep_level;
        logic signed [WEIGHT_W-1:0] weight_now;
        logic signed [WEIGHT_W-1:0] saved_cup_weight;
        logic                       timer_running;
    } t_in_item;

    // One result per tick.
    typedef struct packed {
        logic                       show_taring;
        logic                       show_armed;
        logic                       tare_now;
        logic                       arm_now;
        logic signed [WEIGHT_W-1:0] arm_weight;
        logic                       reset_timer;
        logic                       show_tared;
    } t_res_item;

    // Current configuration, handed to the step logic.
    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [HOLD_W-1:0]     hold_ms;
        logic [DELAY_W-1:0]    tare_delay_ms;
        logic                  sleep_guard_on;
        logic [LOCKOUT_W-1:0]  sleep_lockout_ms;
        logic [TOL_W-1:0]      rearm_tolerance;
        logic [MIN_W-1:0]      rearm_minimum;
    } t_cfg;

endpackage

/* hw/rtl/tap_hold_button_delayed_tare.sv */
// ----------------------------------------------------------------------------
// tap_hold_button_delayed_tare
// Touch-button controller: debounces the pad, tells taps from holds and
// runs a delayed tare with optional auto re-arm, one result per tick.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
//   res      output     o_res_valid / i_res_ready o_res_data (t_res_item)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item passes from input transfer into the input register, then through
// the step logic into the result register.
// One item per cycle is sustained while results are taken; the state update
// in the step logic is the loop that sets this.
// A stalled result holds the result register and, behind it, the input
// register; the input side takes one more item while a result waits.
// Reset is synchronous, active low, and restores the register defaults.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module tap_hold_button_delayed_tare #(
    parameter int TIME_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  thbt_pkg::t_in_item                  i_in_data,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output thbt_pkg::t_res_item                 o_res_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [thbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [thbt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                r_in_valid;
    thbt_pkg::t_in_item  r_in_data;
    logic                r_res_valid;
    thbt_pkg::t_res_item r_res_data;
    thbt_pkg::t_cfg      r_cfg;
    thbt_pkg::t_res_item step_res;
    logic                advance;

    // The held item moves on when the result register is free or emptying.
    assign advance     = r_in_valid && (!r_res_valid || i_res_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res_data;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res_data <= step_res;
        end
    end

    // Configuration registers; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= thbt_pkg::RST_DEBOUNCE;
            r_cfg.hold_ms          <= thbt_pkg::RST_HOLD;
            r_cfg.tare_delay_ms    <= thbt_pkg::RST_DELAY;
            r_cfg.sleep_guard_on   <= thbt_pkg::RST_GUARD;
            r_cfg.sleep_lockout_ms <= thbt_pkg::RST_LOCKOUT;
            r_cfg.rearm_tolerance  <= thbt_pkg::RST_TOL;
            r_cfg.rearm_minimum    <= thbt_pkg::RST_MIN;
        end else if (i_cfg_valid) begin
            unique case (thbt_pkg::t_cfg_idx'(i_cfg_index))
                thbt_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_ms <= i_cfg_data[thbt_pkg::DEBOUNCE_W-1:0];
                end
                thbt_pkg::CFG_HOLD: begin
                    r_cfg.hold_ms <= i_cfg_data[thbt_pkg::HOLD_W-1:0];
                end
                thbt_pkg::CFG_DELAY: begin
                    r_cfg.tare_delay_ms <= i_cfg_data[thbt_pkg::DELAY_W-1:0];
                end
                thbt_pkg::CFG_GUARD: begin
                    r_cfg.sleep_guard_on <= i_cfg_data[0];
                end
                thbt_pkg::CFG_LOCKOUT: begin
                    r_cfg.sleep_lockout_ms <= i_cfg_data[thbt_pkg::LOCKOUT_W-1:0];
                end
                thbt_pkg::CFG_TOL: begin
                    r_cfg.rearm_tolerance <= i_cfg_data[thbt_pkg::TOL_W-1:0];
                end
                thbt_pkg::CFG_MIN: begin
                    r_cfg.rearm_minimum <= i_cfg_data[thbt_pkg::MIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Step logic and per-tick state.
    thbt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in_data),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

endmodule

/* hw/rtl/thbt_core.sv */
// ----------------------------------------------------------------------------
// thbt_core
// Per-tick state and step logic: debounce, tap/hold detection, sleep-pad
// lockout and the delayed tare. State moves on when i_step is high.
// ----------------------------------------------------------------------------
module thbt_core #(
    parameter int TIME_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  thbt_pkg::t_in_item  i_item,
    input  thbt_pkg::t_cfg      i_cfg,
    output thbt_pkg::t_res_item o_res
);

    localparam int CMP_W = (TIME_BITS > thbt_pkg::HOLD_W) ? TIME_BITS : thbt_pkg::HOLD_W;
    localparam logic [TIME_BITS-1:0] TIME_TOP = {TIME_BITS{1'b1}};
    localparam int W = thbt_pkg::WEIGHT_W;

    logic                        r_level, n_level;
    logic                        r_hold_seen, n_hold_seen;
    logic                        r_pending, n_pending;
    logic                        r_is_hold, n_is_hold;
    logic [TIME_BITS-1:0]        r_since_change, n_since_change;
    logic [TIME_BITS-1:0]        r_since_press, n_since_press;
    logic [TIME_BITS-1:0]        r_since_sleep, n_since_sleep;
    logic [thbt_pkg::DELAY_W-1:0] r_delay_left, n_delay_left;
    logic signed [W-1:0]         r_captured, n_captured;

    logic                        ignored;
    logic signed [W:0]           diff;
    logic [W:0]                  mag;
    logic                        rearm_ok;

    // Re-arm match for a tap tare, on the weight held by the end of the tick.
    always_comb begin
        diff     = $signed({n_captured[W-1], n_captured})
                 - $signed({i_item.saved_cup_weight[W-1], i_item.saved_cup_weight});
        mag      = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
        rearm_ok = ($signed({i_item.saved_cup_weight[W-1], i_item.saved_cup_weight})
                    > $signed({{(W+1-thbt_pkg::MIN_W){1'b0}}, i_cfg.rearm_minimum}))
                && (mag <= {{(W+1-thbt_pkg::TOL_W){1'b0}}, i_cfg.rearm_tolerance});
    end

    // Step logic for one tick.
    always_comb begin
        // Time passes on every tick, ignored or not.
        n_since_change = (r_since_change == TIME_TOP) ? r_since_change
                                                      : r_since_change + 1'b1;
        n_since_press  = (r_since_press == TIME_TOP) ? r_since_press
                                                     : r_since_press + 1'b1;
        n_since_sleep  = (r_since_sleep == TIME_TOP) ? r_since_sleep
                                                     : r_since_sleep + 1'b1;
        n_delay_left   = (r_delay_left == '0) ? r_delay_left : r_delay_left - 1'b1;
        n_level        = r_level;
        n_hold_seen    = r_hold_seen;
        n_pending      = r_pending;
        n_is_hold      = r_is_hold;
        n_captured     = r_captured;
        o_res          = '0;
        ignored        = 1'b0;

        // Sleep pad suppression and lockout after release.
        if (i_cfg.sleep_guard_on) begin
            if (i_item.sleep_level) begin
                n_since_sleep = '0;
                ignored       = 1'b1;
            end else if (n_since_sleep < TIME_BITS'(i_cfg.sleep_lockout_ms)) begin
                ignored = 1'b1;
            end
        end

        if (!ignored) begin
            // Debounced edge: a press restarts the hold timer, a release
            // without a hold is a tap.
            if ((i_item.touch_level != r_level)
                && (n_since_change > TIME_BITS'(i_cfg.debounce_ms))) begin
                if (i_item.touch_level) begin
                    n_since_press = '0;
                    n_hold_seen   = 1'b0;
                end else begin
                    if (!r_hold_seen) begin
                        n_captured        = i_item.weight_now;
                        n_is_hold         = 1'b0;
                        n_pending         = 1'b1;
                        n_delay_left      = i_cfg.tare_delay_ms;
                        o_res.show_taring = 1'b1;
                    end
                    n_hold_seen = 1'b0;
                end
                n_level        = i_item.touch_level;
                n_since_change = '0;
            end

            // Hold detection on the raw level.
            if (i_item.touch_level && !n_hold_seen
                && (CMP_W'(n_since_press) >= CMP_W'(i_cfg.hold_ms))) begin
                n_hold_seen      = 1'b1;
                n_captured       = i_item.weight_now;
                n_is_hold        = 1'b1;
                n_pending        = 1'b1;
                n_delay_left     = i_cfg.tare_delay_ms;
                o_res.show_armed = 1'b1;
            end

            // Delayed tare once the countdown has run out.
            if (n_pending && (n_delay_left == '0)) begin
                n_pending      = 1'b0;
                o_res.tare_now = 1'b1;
                if (n_is_hold) begin
                    o_res.arm_now    = 1'b1;
                    o_res.arm_weight = n_captured;
                end else begin
                    o_res.reset_timer = !i_item.timer_running;
                    if (rearm_ok) begin
                        o_res.arm_now    = 1'b1;
                        o_res.arm_weight = i_item.saved_cup_weight;
                    end else begin
                        o_res.show_tared = 1'b1;
                    end
                end
                n_is_hold = 1'b0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= 1'b0;
            r_hold_seen    <= 1'b0;
            r_pending      <= 1'b0;
            r_is_hold      <= 1'b0;
            r_since_change <= '0;
            r_since_press  <= '0;
            r_since_sleep  <= '0;
            r_delay_left   <= '0;
            r_captured     <= '0;
        end else if (i_step) begin
            r_level        <= n_level;
            r_hold_seen    <= n_hold_seen;
            r_pending      <= n_pending;
            r_is_hold      <= n_is_hold;
            r_since_change <= n_since_change;
            r_since_press  <= n_since_press;
            r_since_sleep  <= n_since_sleep;
            r_delay_left   <= n_delay_left;
            r_captured     <= n_captured;
        end
    end

endmodule

/* hw/rtl/thbt_checker.sv */
// ----------------------------------------------------------------------------
// thbt_checker
// Port-level checks on the result channel of the button controller,
// attached to the top level by the bind statement at the end of the file.
// ----------------------------------------------------------------------------
module thbt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_res_valid,
    input logic                i_res_ready,
    input thbt_pkg::t_res_item i_res_data
);

    // A result waiting for transfer keeps its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_data)))
        else $error("result changed while stalled");

    // Arming only happens as part of an executed tare.
    a_arm_with_tare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_data.arm_now) |-> i_res_data.tare_now)
        else $error("arm without tare");

    // The tared message excludes a re-arm and needs an executed tare.
    a_tared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_data.show_tared)
            |-> (i_res_data.tare_now && !i_res_data.arm_now))
        else $error("tared message without a plain tare");

    // A timer reset belongs to a tap tare, which is never a hold arm.
    a_reset_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_data.reset_timer)
            |-> (i_res_data.tare_now && !i_res_data.show_armed))
        else $error("timer reset outside a tap tare");

    // The arm weight is zero unless arming.
    a_arm_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_data.arm_now) |-> (i_res_data.arm_weight == '0))
        else $error("arm weight set without arming");

endmodule

bind tap_hold_button_delayed_tare thbt_checker u_thbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .i_res_data  (o_res_data)
);
